FILE: rtl/sparse_triplet_matrix_add_top_macros.svh
// ----------------------------------------------------------------------------
// Sparse triplet matrix adder - assertion macros
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_MATRIX_ADD_TOP_MACROS_SVH
`define SPARSE_TRIPLET_MATRIX_ADD_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define STMA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define STMA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STMA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define STMA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/stma_pkg.sv
// ----------------------------------------------------------------------------
// Sparse triplet matrix adder - package
// Shared types, codes and field widths.
// ----------------------------------------------------------------------------
package stma_pkg;

    localparam int IDX_W   = 16;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 33;
    localparam int CNT_W   = 6;
    localparam int ENT_W   = 64;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    // Input kinds carried on s_tuser
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    // Result kinds carried on m_tuser
    localparam logic [1:0] STAT_TRIPLET  = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_FINISH,
        ST_REPORT
    } stma_state_t;

    // Row and column on top, so the upper 32 bits form the row-major key.
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } stma_entry_t;

    typedef struct packed {
        logic a_live;
        logic b_live;
    } stma_alu_ctl_t;

    typedef struct packed {
        logic                    emit;
        logic                    take_a;
        logic                    take_b;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] value;
    } stma_alu_res_t;

endpackage

FILE: rtl/stma_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/stma_alu.sv
// ----------------------------------------------------------------------------
// Sparse triplet matrix adder - merge unit
// One key compare and one 33-bit add, used once per merge step.
// ----------------------------------------------------------------------------
module stma_alu (
    input  stma_pkg::stma_entry_t   a_ent,
    input  stma_pkg::stma_entry_t   b_ent,
    input  stma_pkg::stma_alu_ctl_t ctl,
    output stma_pkg::stma_alu_res_t res
);
    import stma_pkg::*;

    logic [2*IDX_W-1:0]      a_key;
    logic [2*IDX_W-1:0]      b_key;
    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] b_ext;
    logic signed [SUM_W-1:0] sum;
    logic                    same;

    assign a_key = {a_ent.row, a_ent.col};
    assign b_key = {b_ent.row, b_ent.col};
    assign a_ext = {a_ent.value[VAL_W-1], a_ent.value};
    assign b_ext = {b_ent.value[VAL_W-1], b_ent.value};
    assign sum   = a_ext + b_ext;
    assign same  = ctl.a_live && ctl.b_live && (a_key == b_key);

    always_comb begin
        res = '0;
        if (same) begin
            // Coincident positions are summed; a zero sum is dropped.
            res.emit   = (sum != '0);
            res.take_a = 1'b1;
            res.take_b = 1'b1;
            res.row    = a_ent.row;
            res.col    = a_ent.col;
            res.value  = sum;
        end else if (!ctl.b_live || (ctl.a_live && (a_key < b_key))) begin
            res.emit   = ctl.a_live;
            res.take_a = ctl.a_live;
            res.row    = a_ent.row;
            res.col    = a_ent.col;
            res.value  = a_ext;
        end else begin
            res.emit   = 1'b1;
            res.take_b = 1'b1;
            res.row    = b_ent.row;
            res.col    = b_ent.col;
            res.value  = b_ext;
        end
    end

endmodule

FILE: rtl/sparse_triplet_matrix_add_top.sv
// ----------------------------------------------------------------------------
// Sparse triplet matrix adder - top level
// Loads two triplet lists into RAM and merges them into their sum.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake         | Contents
//  s_      | in        | tvalid / tready   | load A, load B or start
//  m_      | out       | tvalid / tready   | result triplets, mismatch, empty
//  cfg_    | in        | cfg_we only       | matrix dimensions
//
//  A load is accepted in ST_IDLE. A start with matching dimensions then runs
//  merge steps, each a RAM read in ST_FETCH and then a compare and add in the
//  merge unit in ST_STEP, at most a_count + b_count steps, then closes with a
//  last read that finds both lists drained and the final result from ST_FINISH,
//  or from ST_REPORT when nothing remains; a mismatch goes to ST_REPORT. The
//  input is not ready from start until the final result is registered. A stalled
//  output holds the merge step that needs to hand over a result. Reset clears the
//  counts and sets the dimensions to one; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "sparse_triplet_matrix_add_top_macros.svh"

module sparse_triplet_matrix_add_top #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] row_index, [31:16] col_index, [63:32] entry_value
    input  logic [stma_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] action
    input  logic [1:0]                        s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] out_row, [31:16] out_col, [64:32] out_value,
    // [70:65] entry_count, [71] zero
    output logic [stma_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    // Configuration
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [stma_pkg::IDX_W-1:0]        cfg_wdata
);
    import stma_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(2 * DEPTH + 1);

    stma_state_t state_reg, state_next;

    logic [IDX_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [CW-1:0]    a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;
    logic [CW-1:0]    i_reg, i_next, j_reg, j_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [1:0]       rep_status_reg, rep_status_next;

    logic                    pend_valid_reg, pend_valid_next;
    logic                    pend_load;
    logic [IDX_W-1:0]        pend_row_reg, pend_col_reg;
    logic signed [SUM_W-1:0] pend_value_reg;

    logic                    m_valid_reg, m_valid_next;
    logic                    out_load;
    logic [IDX_W-1:0]        out_row, out_col;
    logic signed [SUM_W-1:0] out_value;
    logic [CNT_W-1:0]        out_count;
    logic [1:0]              out_status;
    logic                    out_last;
    logic [IDX_W-1:0]        m_row_reg, m_col_reg;
    logic signed [SUM_W-1:0] m_value_reg;
    logic [CNT_W-1:0]        m_count_reg;
    logic [1:0]              m_status_reg;
    logic                    m_last_reg;

    logic          in_acc;
    logic          out_free;
    logic          dims_differ;
    stma_entry_t   s_ent;
    stma_entry_t   a_rd, b_rd;
    logic          a_we, b_we;
    stma_alu_ctl_t alu_ctl;
    stma_alu_res_t alu_res;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_acc      = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign dims_differ = (a_rows_reg != b_rows_reg) || (a_cols_reg != b_cols_reg);

    assign s_ent = {s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]};

    assign a_we = in_acc && (s_tuser == ACT_LOAD_A) && (a_cnt_reg < CW'(DEPTH));
    assign b_we = in_acc && (s_tuser == ACT_LOAD_B) && (b_cnt_reg < CW'(DEPTH));

    stma_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (aclk),
        .we    (a_we),
        .waddr (a_cnt_reg[AW-1:0]),
        .wdata (s_ent),
        .raddr (i_reg[AW-1:0]),
        .rdata (a_rd)
    );

    stma_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (aclk),
        .we    (b_we),
        .waddr (b_cnt_reg[AW-1:0]),
        .wdata (s_ent),
        .raddr (j_reg[AW-1:0]),
        .rdata (b_rd)
    );

    // a_live in the upper bit, b_live in the lower.
    assign alu_ctl = {(i_reg < a_cnt_reg), (j_reg < b_cnt_reg)};

    stma_alu u_alu (
        .a_ent (a_rd),
        .b_ent (b_rd),
        .ctl   (alu_ctl),
        .res   (alu_res)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= IDX_W'(1);
            a_cols_reg <= IDX_W'(1);
            b_rows_reg <= IDX_W'(1);
            b_cols_reg <= IDX_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_wdata;
                REG_A_COLS: a_cols_reg <= cfg_wdata;
                REG_B_ROWS: b_rows_reg <= cfg_wdata;
                REG_B_COLS: b_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            a_cnt_reg      <= '0;
            b_cnt_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rep_status_reg <= STAT_TRIPLET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            a_cnt_reg      <= a_cnt_next;
            b_cnt_reg      <= b_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rep_status_reg <= rep_status_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_row_reg   <= alu_res.row;
            pend_col_reg   <= alu_res.col;
            pend_value_reg <= alu_res.value;
        end
        if (out_load) begin
            m_row_reg    <= out_row;
            m_col_reg    <= out_col;
            m_value_reg  <= out_value;
            m_count_reg  <= out_count;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    // Sequencer. One result is held back so that the final one can carry
    // the last mark once the merge is known to be over.
    always_comb begin
        state_next      = state_reg;
        a_cnt_next      = a_cnt_reg;
        b_cnt_next      = b_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rep_status_next = rep_status_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        out_load        = 1'b0;
        out_row         = pend_row_reg;
        out_col         = pend_col_reg;
        out_value       = pend_value_reg;
        out_count       = '0;
        out_status      = STAT_TRIPLET;
        out_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (a_we) begin
                    a_cnt_next = a_cnt_reg + CW'(1);
                end
                if (b_we) begin
                    b_cnt_next = b_cnt_reg + CW'(1);
                end
                if (in_acc && (s_tuser == ACT_START)) begin
                    if (dims_differ) begin
                        rep_status_next = STAT_MISMATCH;
                        state_next      = ST_REPORT;
                    end else begin
                        i_next          = '0;
                        j_next          = '0;
                        k_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (!alu_ctl.a_live && !alu_ctl.b_live) begin
                    state_next = ST_FINISH;
                end else if (!(alu_res.emit && pend_valid_reg && !out_free)) begin
                    if (alu_res.take_a) begin
                        i_next = i_reg + CW'(1);
                    end
                    if (alu_res.take_b) begin
                        j_next = j_reg + CW'(1);
                    end
                    if (alu_res.emit) begin
                        k_next          = k_reg + KW'(1);
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg) begin
                            out_load     = 1'b1;
                            m_valid_next = 1'b1;
                        end
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (!pend_valid_reg) begin
                    rep_status_next = STAT_EMPTY;
                    state_next      = ST_REPORT;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    m_valid_next    = 1'b1;
                    out_count       = CNT_W'(k_reg);
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    a_cnt_next      = '0;
                    b_cnt_next      = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    out_row      = '0;
                    out_col      = '0;
                    out_value    = '0;
                    out_status   = rep_status_reg;
                    out_last     = 1'b1;
                    a_cnt_next   = '0;
                    b_cnt_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_value_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    `STMA_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, (a_cnt_reg <= CW'(DEPTH)))
    `STMA_ASSERT_IMP(step_in_range, aclk, aresetn, (state_reg == ST_STEP),
        ((i_reg <= a_cnt_reg) && (j_reg <= b_cnt_reg)))
    `STMA_ASSERT_NXT(mismatch_reported, aclk, aresetn,
        (in_acc && (s_tuser == ACT_START) && dims_differ),
        ((state_reg == ST_REPORT) && (rep_status_reg == STAT_MISMATCH)))
    `STMA_ASSERT_IMP(count_on_last_only, aclk, aresetn, (m_tvalid && !m_tlast),
        ((m_count_reg == '0) && (m_status_reg == STAT_TRIPLET)))

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse triplet matrix adder - testbench
// Streams triplet loads and merge starts into the block and keeps its own
// copy of both stores, counts and dimensions. Each start is turned into the
// triplets it should give. A checker compares every result transfer, field by
// field, with the oldest of those. Directed cases come first, then random
// merges under several patterns of idle and stall on both streams.
// ----------------------------------------------------------------------------
module tb;
    import stma_pkg::*;

    localparam int DEPTH = 16;
    // Action code the block does not know; it must be ignored.
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] value;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } sum_item_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [IDX_W-1:0]    cfg_wdata;

    // Our own copy of the block's dimensions and triplet stores.
    logic [IDX_W-1:0] dim_a_rows = 16'd1;
    logic [IDX_W-1:0] dim_a_cols = 16'd1;
    logic [IDX_W-1:0] dim_b_rows = 16'd1;
    logic [IDX_W-1:0] dim_b_cols = 16'd1;
    stma_entry_t      a_ent [DEPTH];
    stma_entry_t      b_ent [DEPTH];
    int unsigned      a_len = 0;
    int unsigned      b_len = 0;
    sum_item_t        expected_sums [$];

    int n_errors       = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    sparse_triplet_matrix_add_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Works out what one accepted input transfer does to the stores and
    // which results it should give.
    task automatic update_sum_model(input logic [1:0] act, input logic [S_DATA_W-1:0] data);
        stma_entry_t             ent;
        stma_entry_t             ea;
        stma_entry_t             eb;
        logic signed [VAL_W-1:0] va;
        logic signed [VAL_W-1:0] vb;
        logic signed [SUM_W-1:0] total;
        logic [IDX_W-1:0]        er;
        logic [IDX_W-1:0]        ec;
        sum_item_t               held;
        bit                      have_held;
        bit                      give;
        int unsigned             ia;
        int unsigned             ib;
        int unsigned             n_out;
        ent = {data[15:0], data[31:16], data[63:32]};
        have_held = 1'b0;
        held = '0;
        ia = 0;
        ib = 0;
        n_out = 0;
        case (act)
            ACT_LOAD_A: begin
                if (a_len < DEPTH) begin
                    a_ent[a_len] = ent;
                    a_len++;
                end
            end
            ACT_LOAD_B: begin
                if (b_len < DEPTH) begin
                    b_ent[b_len] = ent;
                    b_len++;
                end
            end
            ACT_START: begin
                if (dim_a_rows != dim_b_rows || dim_a_cols != dim_b_cols) begin
                    held.status = STAT_MISMATCH;
                    held.last = 1'b1;
                    expected_sums.push_back(held);
                end else begin
                    while (ia < a_len || ib < b_len) begin
                        ea = (ia < a_len) ? a_ent[ia] : '0;
                        eb = (ib < b_len) ? b_ent[ib] : '0;
                        va = ea.value;
                        vb = eb.value;
                        give = 1'b1;
                        if (ia < a_len && ib < b_len && {ea.row, ea.col} == {eb.row, eb.col}) begin
                            total = va + vb;
                            give = (total != 0);
                            er = ea.row;
                            ec = ea.col;
                            ia++;
                            ib++;
                        end else if (ib >= b_len ||
                                     (ia < a_len && {ea.row, ea.col} < {eb.row, eb.col})) begin
                            total = va;
                            er = ea.row;
                            ec = ea.col;
                            ia++;
                        end else begin
                            total = vb;
                            er = eb.row;
                            ec = eb.col;
                            ib++;
                        end
                        // Hold each triplet back by one so the final one can take
                        // the last mark and the count.
                        if (give) begin
                            if (have_held)
                                expected_sums.push_back(held);
                            held = '0;
                            held.row = er;
                            held.col = ec;
                            held.value = total;
                            held.status = STAT_TRIPLET;
                            have_held = 1'b1;
                            n_out++;
                        end
                    end
                    if (!have_held) begin
                        held = '0;
                        held.status = STAT_EMPTY;
                    end else begin
                        held.count = n_out[CNT_W-1:0];
                    end
                    held.last = 1'b1;
                    expected_sums.push_back(held);
                end
                a_len = 0;
                b_len = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        sum_item_t exp_sum;
        if (expected_sums.size() == 0) begin
            report_error($sformatf("result transfer with none expected, status %0d", m_tuser));
        end else begin
            exp_sum = expected_sums.pop_front();
            check_field("out_row", 64'(m_tdata[15:0]), 64'(exp_sum.row));
            check_field("out_col", 64'(m_tdata[31:16]), 64'(exp_sum.col));
            check_field("out_value", 64'(m_tdata[64:32]), 64'({exp_sum.value}));
            check_field("entry_count", 64'(m_tdata[70:65]), 64'(exp_sum.count));
            check_field("tdata pad", 64'(m_tdata[71]), 64'(1'b0));
            check_field("status", 64'(m_tuser), 64'(exp_sum.status));
            check_field("last", 64'(m_tlast), 64'(exp_sum.last));
        end
    endtask

    // Both streams are sampled here, at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                update_sum_model(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic stma_entry_t trip(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] value);
        stma_entry_t ent;
        ent.row = row;
        ent.col = col;
        ent.value = value;
        return ent;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 16'd1;
            1: return 16'hFFFF;
            default: return IDX_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Returns at the rising edge where the transfer took place, with tvalid
    // still high, so a following item can go straight on.
    task automatic send_item(input logic [1:0] act, input stma_entry_t ent);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {ent.value, ent.col, ent.row};
        do @(posedge aclk); while (!s_tready);
        if (act != ACT_NONE)
            items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [IDX_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            REG_A_ROWS: dim_a_rows = value;
            REG_A_COLS: dim_a_cols = value;
            REG_B_ROWS: dim_b_rows = value;
            REG_B_COLS: dim_b_cols = value;
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input logic [IDX_W-1:0] ar, input logic [IDX_W-1:0] ac,
                            input logic [IDX_W-1:0] br, input logic [IDX_W-1:0] bc);
        write_reg(REG_A_ROWS, ar);
        write_reg(REG_A_COLS, ac);
        write_reg(REG_B_ROWS, br);
        write_reg(REG_B_COLS, bc);
    endtask

    // Extreme values, an equal position summing past 32 bits, a sum of zero,
    // a loaded zero and an unknown action, all with the reset dimensions.
    task automatic test_sums_and_extremes();
        send_item(ACT_START, trip(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(ACT_LOAD_A, trip(16'h0000, 16'h0000, 32'h7FFF_FFFF));
        send_item(ACT_LOAD_B, trip(16'h0000, 16'h0000, 32'h7FFF_FFFF));
        send_item(ACT_LOAD_A, trip(16'h0000, 16'h0001, 32'd5));
        send_item(ACT_LOAD_B, trip(16'h0000, 16'h0001, -32'sd5));
        send_item(ACT_LOAD_B, trip(16'h0002, 16'h0000, 32'hFFFF_FFFF));
        send_item(ACT_LOAD_A, trip(16'h0003, 16'h0007, 32'h0));
        send_item(ACT_NONE, trip(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(ACT_LOAD_A, trip(16'hFFFE, 16'hFFFE, 32'h8000_0000));
        send_item(ACT_LOAD_B, trip(16'hFFFE, 16'hFFFE, 32'h8000_0000));
        send_item(ACT_START, trip(16'h1234, 16'h5678, 32'h9ABC_DEF0));
        send_item(ACT_LOAD_A, trip(16'h0001, 16'h0001, 32'd7));
        send_item(ACT_LOAD_B, trip(16'h0001, 16'h0001, -32'sd7));
        send_item(ACT_START, trip(16'h0, 16'h0, 32'h0));
    endtask

    // Lists out of row-major order are merged step by step all the same.
    task automatic test_unsorted_lists();
        send_item(ACT_LOAD_A, trip(16'h0005, 16'h0000, 32'd1));
        send_item(ACT_LOAD_A, trip(16'h0001, 16'h0000, 32'd2));
        send_item(ACT_LOAD_B, trip(16'h0003, 16'h0000, 32'd4));
        send_item(ACT_START, trip(16'h0, 16'h0, 32'h0));
    endtask

    // A mismatch gives one result and must also clear both stores.
    task automatic test_dim_mismatch();
        wait_idle();
        set_dims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        send_item(ACT_LOAD_A, trip(16'h0004, 16'h0004, 32'd9));
        send_item(ACT_LOAD_B, trip(16'h0004, 16'h0005, 32'd3));
        send_item(ACT_START, trip(16'h0, 16'h0, 32'h0));
        wait_idle();
        set_dims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_START, trip(16'h0, 16'h0, 32'h0));
    endtask

    // Both stores overfilled with disjoint positions: the largest merge there is.
    task automatic test_store_full();
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_item(ACT_LOAD_A, trip(i[IDX_W-1:0], 16'h0000, rand_value()));
            send_item(ACT_LOAD_B, trip(i[IDX_W-1:0], 16'h0001, rand_value()));
        end
        send_item(ACT_START, trip(IDX_W'($urandom), IDX_W'($urandom), $urandom));
    endtask

    // One random merge: a walk over row-major positions, each one going to
    // A, B or both, then the loads in a random interleave and a start.
    task automatic random_merge();
        stma_entry_t      a_q [$];
        stma_entry_t      b_q [$];
        stma_entry_t      ent;
        logic [31:0]      key;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        int               n_keys;
        int               pick;
        if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            r = pick_dim();
            c = pick_dim();
            case ($urandom_range(0, 5))
                0: set_dims(r, c, (r == 16'hFFFF) ? 16'd1 : r + 16'd1, c);
                1: set_dims(r, c, r, (c == 16'hFFFF) ? 16'd1 : c + 16'd1);
                default: set_dims(r, c, r, c);
            endcase
        end
        key = $urandom;
        n_keys = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 26) : $urandom_range(0, 8);
        for (int k = 0; k < n_keys; k++) begin
            key += ($urandom_range(0, 3) == 0) ? ($urandom_range(1, 4) << IDX_W)
                                               : $urandom_range(1, 3);
            ent = trip(key[31:16], key[15:0], rand_value());
            pick = $urandom_range(0, 2);
            if (pick != 1)
                a_q.push_back(ent);
            if (pick != 0) begin
                if (pick == 2 && $urandom_range(0, 2) == 0)
                    ent.value = -ent.value;
                else
                    ent.value = rand_value();
                b_q.push_back(ent);
            end
        end
        // Now and then break the ordering of list A.
        if ($urandom_range(0, 7) == 0 && a_q.size() > 1) begin
            ent = a_q[0];
            a_q[0] = a_q[a_q.size() - 1];
            a_q[a_q.size() - 1] = ent;
        end
        while (a_q.size() != 0 || b_q.size() != 0) begin
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_NONE, {$urandom, $urandom});
            if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 1))
                send_item(ACT_LOAD_A, a_q.pop_front());
            else
                send_item(ACT_LOAD_B, b_q.pop_front());
        end
        send_item(ACT_START, {$urandom, $urandom});
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int first;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        first = items_sent;
        while (items_sent - first < n_items)
            random_merge();
        // The sender holds off here until every result has come back.
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_LOAD_A;
        m_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = REG_A_ROWS;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_sums_and_extremes();
        test_unsorted_lists();
        test_dim_mismatch();
        test_store_full();
        test_random_traffic(0, 0, 55);
        test_random_traffic(46, 0, 55);
        test_random_traffic(0, 46, 55);
        test_random_traffic(36, 36, 55);

        wait_idle();
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/stma_pkg.sv
rtl/stma_ram.sv
rtl/stma_alu.sv
rtl/sparse_triplet_matrix_add_top.sv
dv/tb.sv
